// ===== rtl/pru_pkg.sv =====
package pru_pkg;

   localparam int SCALE_REG_W = 5;
   localparam int WIDTH_REG_W = 12;
   localparam int CSR_DATA_W  = 12;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IN_WIDTH = 1'b1;

   localparam logic OP_NEW    = 1'b0;
   localparam logic OP_REPLAY = 1'b1;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef struct packed {
      pixel_type  pix;
      logic       replay;
      logic       err;
      logic       row_done;
      logic [1:0] pad;
   } item_type;

endpackage

// ===== rtl/pru_ifs.sv =====
interface pru_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] blue;
   logic [7:0] green;
   logic [7:0] red;

   modport source (output valid, output opcode, output blue, output green, output red,
                   input ready);
   modport sink (input valid, input opcode, input blue, input green, input red,
                 output ready);
endinterface

interface pru_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_blue;
   logic [7:0] out_green;
   logic [7:0] out_red;
   logic       run_last;
   logic       row_end;
   logic [1:0] pad_bytes;
   logic       seq_error;

   modport source (output valid, output out_blue, output out_green, output out_red,
                   output run_last, output row_end, output pad_bytes, output seq_error,
                   input ready);
   modport sink (input valid, input out_blue, input out_green, input out_red,
                 input run_last, input row_end, input pad_bytes, input seq_error,
                 output ready);
endinterface

// ===== rtl/pixel_replication_upscaler.sv =====
// Nearest-neighbor integer upscaler. Each accepted request emits scale result
// pixels at one per cycle while the output is ready (one result for an
// out-of-sequence request), with a single output beat per cycle; a request
// passes the sequencer's s1 register and then the emitter's em register before
// its first result leaves, and a request is taken while the previous run is
// still being emitted. Source pixels go into a one-port-write, one-port-read
// line buffer of MAX_WIDTH entries; replay requests read it back in the cycle
// after acceptance. The buffer is not cleared after reset and needs no clearing
// pass. Write scale and in_width only while no request is in flight.
module pixel_replication_upscaler #(
   parameter int MAX_SCALE = 16,
   parameter int MAX_WIDTH = 2048
) (
   input  logic                                  clock,
   input  logic                                  reset,
   pru_req_if.sink                               req_ch,
   pru_rsp_if.source                             rsp_ch,
   input  logic                                  csr_wr_en,
   input  logic [pru_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [pru_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int SW  = MAX_SCALE > 1 ? $clog2(MAX_SCALE) : 1;
   localparam int CW  = MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1;
   localparam int SEW = SW + 1;
   localparam int WEW = CW + 1;

   logic [SEW-1:0]    scale_eff_ff, scale_eff_in;
   logic [WEW-1:0]    width_eff_ff, width_eff_in;
   logic [SW-1:0]     scale_m1;
   logic [CW-1:0]     width_m1;
   logic [4:0]        pad_prod;
   logic [1:0]        pad;
   logic              item_valid;
   logic              item_ready;
   pru_pkg::item_type item;

   always_comb begin
      int sv;
      int wv;
      sv = int'(csr_wdata[pru_pkg::SCALE_REG_W-1:0]);
      wv = int'(csr_wdata[pru_pkg::WIDTH_REG_W-1:0]);
      scale_eff_in = scale_eff_ff;
      width_eff_in = width_eff_ff;
      if (csr_wr_en) begin
         case (csr_index)
            pru_pkg::CSR_SCALE: begin
               scale_eff_in = (sv == 0) ? SEW'(1) : (sv > MAX_SCALE) ? SEW'(MAX_SCALE) : SEW'(sv);
            end
            pru_pkg::CSR_IN_WIDTH: begin
               width_eff_in = (wv == 0) ? WEW'(1) : (wv > MAX_WIDTH) ? WEW'(MAX_WIDTH) : WEW'(wv);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_eff_ff <= SEW'(1);
         width_eff_ff <= WEW'(1);
      end else begin
         scale_eff_ff <= scale_eff_in;
         width_eff_ff <= width_eff_in;
      end
   end

   assign scale_m1 = SW'(scale_eff_ff - SEW'(1));
   assign width_m1 = CW'(width_eff_ff - WEW'(1));
   assign pad_prod = 5'(scale_eff_ff[1:0]) * 5'(width_eff_ff[1:0]) * 5'd3;
   assign pad      = 2'(~pad_prod[1:0] + 2'd1);

   pru_seq #(
      .MAX_SCALE (MAX_SCALE),
      .MAX_WIDTH (MAX_WIDTH)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .scale_m1   (scale_m1),
      .width_m1   (width_m1),
      .pad        (pad),
      .item_valid (item_valid),
      .item       (item),
      .item_ready (item_ready)
   );

   pru_emit #(
      .MAX_SCALE (MAX_SCALE)
   ) u_emit (
      .clock      (clock),
      .reset      (reset),
      .scale_m1   (scale_m1),
      .item_valid (item_valid),
      .item       (item),
      .item_ready (item_ready),
      .rsp_ch     (rsp_ch)
   );

`ifndef SYNTHESIS
   a_stall_means_busy: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> rsp_ch.valid)
      else $error("request stalled while output is idle");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.ready && !rsp_ch.run_last |=> rsp_ch.valid)
      else $error("run ended before its last result");

   a_row_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.row_end || rsp_ch.seq_error) |-> rsp_ch.run_last)
      else $error("row end or error result is not last of its run");
`endif

endmodule

// ===== rtl/pru_ram.sv =====
module pru_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pru_seq.sv =====
module pru_seq #(
   parameter int MAX_SCALE = 16,
   parameter int MAX_WIDTH = 2048
) (
   input  logic                     clock,
   input  logic                     reset,
   pru_req_if.sink                  req_ch,
   input  logic [(MAX_SCALE > 1 ? $clog2(MAX_SCALE) : 1)-1:0] scale_m1,
   input  logic [(MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1)-1:0] width_m1,
   input  logic [1:0]               pad,
   output logic                     item_valid,
   output pru_pkg::item_type        item,
   input  logic                     item_ready
);

   localparam int SW = MAX_SCALE > 1 ? $clog2(MAX_SCALE) : 1;
   localparam int CW = MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1;

   logic [CW-1:0]      column_ff, column_in;
   logic [SW-1:0]      repeat_ff, repeat_in;
   logic               phase_ff, phase_in;
   logic               s1_valid_ff, s1_valid_in;
   pru_pkg::item_type  s1_item_ff, s1_item_in;

   logic               accept;
   logic               err;
   logic               row_done;
   logic [SW-1:0]      repeat_inc;
   pru_pkg::pixel_type new_pix;
   pru_pkg::pixel_type rd_pix;

   assign req_ch.ready = !s1_valid_ff || item_ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign err          = req_ch.opcode != phase_ff;
   assign row_done     = column_ff >= width_m1;
   assign repeat_inc   = repeat_ff + SW'(1);
   assign new_pix      = '{red: req_ch.red, green: req_ch.green, blue: req_ch.blue};

   pru_ram #(
      .WIDTH ($bits(pru_pkg::pixel_type)),
      .DEPTH (MAX_WIDTH)
   ) u_line (
      .clock   (clock),
      .wr_en   (accept && !err && req_ch.opcode == pru_pkg::OP_NEW),
      .wr_addr (column_ff),
      .wr_data (new_pix),
      .rd_en   (accept && !err && req_ch.opcode == pru_pkg::OP_REPLAY),
      .rd_addr (column_ff),
      .rd_data (rd_pix)
   );

   always_comb begin
      column_in   = column_ff;
      repeat_in   = repeat_ff;
      phase_in    = phase_ff;
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      if (accept) begin
         s1_valid_in         = 1'b1;
         s1_item_in.pix      = err ? '0 : new_pix;
         s1_item_in.replay   = !err && req_ch.opcode == pru_pkg::OP_REPLAY;
         s1_item_in.err      = err;
         s1_item_in.row_done = !err && row_done;
         s1_item_in.pad      = pad;
         if (!err) begin
            if (row_done) begin
               column_in = '0;
               if (req_ch.opcode == pru_pkg::OP_NEW) begin
                  if (scale_m1 != '0) begin
                     phase_in  = pru_pkg::OP_REPLAY;
                     repeat_in = '0;
                  end
               end else if (repeat_inc == '0 || repeat_inc >= scale_m1) begin
                  phase_in  = pru_pkg::OP_NEW;
                  repeat_in = '0;
               end else begin
                  repeat_in = repeat_inc;
               end
            end else begin
               column_in = column_ff + CW'(1);
            end
         end
      end else if (item_ready) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff   <= '0;
         repeat_ff   <= '0;
         phase_ff    <= pru_pkg::OP_NEW;
         s1_valid_ff <= 1'b0;
      end else begin
         column_ff   <= column_in;
         repeat_ff   <= repeat_in;
         phase_ff    <= phase_in;
         s1_valid_ff <= s1_valid_in;
      end
      s1_item_ff <= s1_item_in;
   end

   always_comb begin
      item = s1_item_ff;
      if (s1_item_ff.replay) begin
         item.pix = rd_pix;
      end
   end

   assign item_valid = s1_valid_ff;

endmodule

// ===== rtl/pru_emit.sv =====
module pru_emit #(
   parameter int MAX_SCALE = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [(MAX_SCALE > 1 ? $clog2(MAX_SCALE) : 1)-1:0] scale_m1,
   input  logic                     item_valid,
   input  pru_pkg::item_type        item,
   output logic                     item_ready,
   pru_rsp_if.source                rsp_ch
);

   localparam int SW = MAX_SCALE > 1 ? $clog2(MAX_SCALE) : 1;

   logic              em_valid_ff, em_valid_in;
   logic [SW-1:0]     em_k_ff, em_k_in;
   logic [SW-1:0]     em_last_ff, em_last_in;
   pru_pkg::item_type em_item_ff, em_item_in;

   logic beat_done;
   logic at_last;
   logic run_done;

   assign at_last    = em_k_ff == em_last_ff;
   assign beat_done  = em_valid_ff && rsp_ch.ready;
   assign run_done   = beat_done && at_last;
   assign item_ready = !em_valid_ff || run_done;

   always_comb begin
      em_valid_in = em_valid_ff;
      em_k_in     = em_k_ff;
      em_last_in  = em_last_ff;
      em_item_in  = em_item_ff;
      if (item_valid && item_ready) begin
         em_valid_in = 1'b1;
         em_k_in     = '0;
         em_last_in  = item.err ? '0 : scale_m1;
         em_item_in  = item;
      end else if (run_done) begin
         em_valid_in = 1'b0;
      end else if (beat_done) begin
         em_k_in = em_k_ff + SW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         em_valid_ff <= 1'b0;
         em_k_ff     <= '0;
      end else begin
         em_valid_ff <= em_valid_in;
         em_k_ff     <= em_k_in;
      end
      em_last_ff <= em_last_in;
      em_item_ff <= em_item_in;
   end

   assign rsp_ch.valid     = em_valid_ff;
   assign rsp_ch.out_blue  = em_item_ff.pix.blue;
   assign rsp_ch.out_green = em_item_ff.pix.green;
   assign rsp_ch.out_red   = em_item_ff.pix.red;
   assign rsp_ch.run_last  = at_last;
   assign rsp_ch.row_end   = at_last && em_item_ff.row_done;
   assign rsp_ch.pad_bytes = (at_last && em_item_ff.row_done) ? em_item_ff.pad : 2'd0;
   assign rsp_ch.seq_error = em_item_ff.err;

endmodule

// ===== dv/tb_pixel_replication_upscaler.sv =====
module tb_pixel_replication_upscaler;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_SCALE    = 16;
   localparam int MAX_WIDTH    = 2048;
   localparam int RANDOM_ITEMS = 350;
   localparam int LONG_HOLD    = 300;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic       run_last;
      logic       row_end;
      logic [1:0] pad;
      logic       seq_error;
   } upscaled_pixel_type;

   typedef enum logic [0:0] {ROW_REQ, ROW_CFG} row_kind_type;

   typedef struct packed {
      row_kind_type                      kind;
      logic                              op;
      logic [23:0]                       pix;
      logic [pru_pkg::CSR_INDEX_W-1:0]   idx;
      logic [pru_pkg::CSR_DATA_W-1:0]    data;
      logic                              has_exp;
      upscaled_pixel_type                exp;
   } directed_row_type;

   localparam upscaled_pixel_type SEQ_ERR_PIXEL =
      '{8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 2'd0, 1'b1};

   logic clock;
   logic reset;
   logic                            csr_wr_en;
   logic [pru_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [pru_pkg::CSR_DATA_W-1:0]  csr_wdata;

   pru_req_if req_if ();
   pru_rsp_if rsp_if ();

   pixel_replication_upscaler u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // upscaler state mirror
   logic [4:0]  scale_reg;
   logic [11:0] width_reg;
   logic [23:0] line_mem [MAX_WIDTH];
   logic [10:0] column;
   logic [3:0]  repeat_cnt;
   logic        replay_ph;

   upscaled_pixel_type expected_pixels[$];
   upscaled_pixel_type run_pixels[$];
   directed_row_type   directed_rows[$];

   int mismatch_count = 0;
   bit idle_on = 1'b1;
   bit long_hold_req = 1'b0;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic int clamp_size(int v, int hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   task automatic upscale_request(input logic op, input logic [23:0] pix_in);
      int s;
      int w;
      int pad_i;
      logic [23:0] pix;
      bit done;
      upscaled_pixel_type e;
      run_pixels.delete();
      if (op != replay_ph) begin
         run_pixels.push_back(SEQ_ERR_PIXEL);
         return;
      end
      s = clamp_size(int'(scale_reg), MAX_SCALE);
      w = clamp_size(int'(width_reg), MAX_WIDTH);
      if (op == pru_pkg::OP_NEW) begin
         pix = pix_in;
         line_mem[column] = pix;
      end else begin
         pix = line_mem[column];
      end
      done = (int'(column) >= w - 1);
      pad_i = (4 - ((w * s * 3) % 4)) % 4;
      for (int k = 0; k < s; k++) begin
         e.blue      = pix[7:0];
         e.green     = pix[15:8];
         e.red       = pix[23:16];
         e.run_last  = (k == s - 1);
         e.row_end   = (k == s - 1) && done;
         e.pad       = e.row_end ? 2'(pad_i) : 2'd0;
         e.seq_error = 1'b0;
         run_pixels.push_back(e);
      end
      if (done) begin
         column = '0;
         if (op == pru_pkg::OP_NEW) begin
            if (s > 1) begin
               replay_ph  = 1'b1;
               repeat_cnt = '0;
            end
         end else begin
            repeat_cnt = repeat_cnt + 4'd1;
            if (repeat_cnt == 4'd0 || int'(repeat_cnt) >= s - 1) begin
               replay_ph  = 1'b0;
               repeat_cnt = '0;
            end
         end
      end else begin
         column = column + 11'd1;
      end
   endtask

   task automatic report_mismatch(input string what, input upscaled_pixel_type got,
                                  input upscaled_pixel_type want);
      mismatch_count++;
      $display("%0t %s: got b=%h g=%h r=%h last=%b end=%b pad=%0d err=%b,",
               $time, what, got.blue, got.green, got.red, got.run_last, got.row_end,
               got.pad, got.seq_error,
               " want b=%h g=%h r=%h last=%b end=%b pad=%0d err=%b",
               want.blue, want.green, want.red, want.run_last,
               want.row_end, want.pad, want.seq_error);
   endtask

   always @(posedge clock) begin : check_results
      upscaled_pixel_type got;
      upscaled_pixel_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = '{rsp_if.out_blue, rsp_if.out_green, rsp_if.out_red, rsp_if.run_last,
                 rsp_if.row_end, rsp_if.pad_bytes, rsp_if.seq_error};
         if (expected_pixels.size() == 0) begin
            report_mismatch("unexpected result", got, '0);
         end else begin
            want = expected_pixels.pop_front();
            if (got !== want) report_mismatch("result mismatch", got, want);
         end
      end
   end

   initial begin : result_sink
      int stall_left;
      stall_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left = LONG_HOLD - 1;
            rsp_if.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 13);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // entered and left at a falling edge with nothing yet scheduled on valid
   task automatic push_request(input logic op, input logic [23:0] pix, input bit use_typed,
                               input upscaled_pixel_type typed);
      req_if.valid  <= 1'b1;
      req_if.opcode <= op;
      req_if.blue   <= pix[7:0];
      req_if.green  <= pix[15:8];
      req_if.red    <= pix[23:16];
      do @(posedge clock); while (!req_if.ready);
      upscale_request(op, pix);
      if (use_typed) expected_pixels.push_back(typed);
      else foreach (run_pixels[i]) expected_pixels.push_back(run_pixels[i]);
      @(negedge clock);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
   endtask

   task automatic drain_requests();
      req_if.valid <= 1'b0;
      while (expected_pixels.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [pru_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [pru_pkg::CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == pru_pkg::CSR_SCALE) scale_reg = data[4:0];
      else width_reg = data[11:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   function automatic directed_row_type cfg_row(logic [pru_pkg::CSR_INDEX_W-1:0] idx,
                                                logic [pru_pkg::CSR_DATA_W-1:0] data);
      return '{ROW_CFG, pru_pkg::OP_NEW, 24'h0, idx, data, 1'b0, upscaled_pixel_type'('0)};
   endfunction

   function automatic directed_row_type pix_row(logic op, logic [7:0] b, logic [7:0] g,
                                                logic [7:0] r);
      return '{ROW_REQ, op, {r, g, b}, pru_pkg::CSR_SCALE, 12'h0, 1'b0,
               upscaled_pixel_type'('0)};
   endfunction

   function automatic directed_row_type pix_row_exp(logic op, logic [7:0] b, logic [7:0] g,
                                                    logic [7:0] r, upscaled_pixel_type e);
      return '{ROW_REQ, op, {r, g, b}, pru_pkg::CSR_SCALE, 12'h0, 1'b1, e};
   endfunction

   initial begin : stimulus
      directed_row_type row;
      logic [4:0]  new_scale;
      logic [11:0] new_width;
      logic        op;
      int items_sent;
      int seg;

      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_index     = pru_pkg::CSR_SCALE;
      csr_wdata     = '0;
      req_if.valid  = 1'b0;
      req_if.opcode = pru_pkg::OP_NEW;
      req_if.blue   = '0;
      req_if.green  = '0;
      req_if.red    = '0;
      scale_reg     = 5'd1;
      width_reg     = 12'd1;
      column        = '0;
      repeat_cnt    = '0;
      replay_ph     = 1'b0;

      directed_rows.push_back(pix_row_exp(pru_pkg::OP_NEW, 8'hff, 8'h00, 8'hff,
                                          '{8'hff, 8'h00, 8'hff, 1'b1, 1'b1, 2'd1, 1'b0}));
      directed_rows.push_back(pix_row_exp(pru_pkg::OP_REPLAY, 8'h00, 8'h00, 8'h00,
                                          SEQ_ERR_PIXEL));
      directed_rows.push_back(pix_row_exp(pru_pkg::OP_NEW, 8'h00, 8'hff, 8'h00,
                                          '{8'h00, 8'hff, 8'h00, 1'b1, 1'b1, 2'd1, 1'b0}));
      directed_rows.push_back(cfg_row(pru_pkg::CSR_SCALE, 12'h000));
      directed_rows.push_back(cfg_row(pru_pkg::CSR_IN_WIDTH, 12'h000));
      directed_rows.push_back(pix_row_exp(pru_pkg::OP_NEW, 8'h00, 8'h00, 8'hff,
                                          '{8'h00, 8'h00, 8'hff, 1'b1, 1'b1, 2'd1, 1'b0}));
      directed_rows.push_back(cfg_row(pru_pkg::CSR_SCALE, 12'hfff));
      directed_rows.push_back(cfg_row(pru_pkg::CSR_IN_WIDTH, 12'h001));
      directed_rows.push_back(pix_row(pru_pkg::OP_NEW, 8'h5a, 8'ha5, 8'h3c));
      directed_rows.push_back(pix_row_exp(pru_pkg::OP_NEW, 8'hff, 8'hff, 8'hff,
                                          SEQ_ERR_PIXEL));
      directed_rows.push_back(pix_row(pru_pkg::OP_REPLAY, 8'hff, 8'hff, 8'hff));
      directed_rows.push_back(cfg_row(pru_pkg::CSR_SCALE, 12'h002));
      directed_rows.push_back(pix_row(pru_pkg::OP_REPLAY, 8'h00, 8'h00, 8'h00));
      directed_rows.push_back(pix_row_exp(pru_pkg::OP_REPLAY, 8'h00, 8'h00, 8'h00,
                                          SEQ_ERR_PIXEL));
      directed_rows.push_back(pix_row(pru_pkg::OP_NEW, 8'hc3, 8'h3c, 8'h81));
      directed_rows.push_back(pix_row(pru_pkg::OP_REPLAY, 8'h7e, 8'h81, 8'h18));
      directed_rows.push_back(cfg_row(pru_pkg::CSR_SCALE, 12'hfe1));
      directed_rows.push_back(cfg_row(pru_pkg::CSR_IN_WIDTH, 12'hfff));
      directed_rows.push_back(pix_row(pru_pkg::OP_NEW, 8'h12, 8'h34, 8'h56));
      directed_rows.push_back(pix_row(pru_pkg::OP_NEW, 8'h80, 8'h7f, 8'h01));
      directed_rows.push_back(cfg_row(pru_pkg::CSR_IN_WIDTH, 12'h003));
      directed_rows.push_back(pix_row_exp(pru_pkg::OP_NEW, 8'h01, 8'h80, 8'hfe,
                                          '{8'h01, 8'h80, 8'hfe, 1'b1, 1'b1, 2'd3, 1'b0}));
      directed_rows.push_back(cfg_row(pru_pkg::CSR_SCALE, 12'h003));
      directed_rows.push_back(cfg_row(pru_pkg::CSR_IN_WIDTH, 12'h002));
      directed_rows.push_back(pix_row(pru_pkg::OP_NEW, 8'haa, 8'h55, 8'h00));
      directed_rows.push_back(pix_row(pru_pkg::OP_NEW, 8'h55, 8'haa, 8'hff));
      repeat (4) directed_rows.push_back(pix_row(pru_pkg::OP_REPLAY, 8'h0f, 8'hf0, 8'h33));
      directed_rows.push_back(pix_row_exp(pru_pkg::OP_REPLAY, 8'hff, 8'h00, 8'hff,
                                          SEQ_ERR_PIXEL));
      directed_rows.push_back(pix_row(pru_pkg::OP_NEW, 8'h00, 8'h00, 8'h00));

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_CFG) begin
            drain_requests();
            write_csr(row.idx, row.data);
         end else begin
            push_request(row.op, row.pix, row.has_exp, row.exp);
         end
      end

      items_sent = 0;
      seg = 0;
      while (items_sent < RANDOM_ITEMS) begin
         drain_requests();
         if (items_sent >= RANDOM_ITEMS - 60) idle_on = 1'b0;
         if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
               0: new_scale = 5'd0;
               1: new_scale = 5'd16;
               2: new_scale = 5'(17 + $urandom_range(0, 14));
               default: new_scale = 5'd1;
            endcase
            new_width = 12'($urandom_range(0, 1));
         end else begin
            new_scale = 5'($urandom_range(1, MAX_SCALE));
            new_width = 12'($urandom_range(1, 6));
         end
         if ($urandom_range(0, 3) != 0) write_csr(pru_pkg::CSR_SCALE, {7'($urandom), new_scale});
         // a wider row during replay would read entries never written
         if ($urandom_range(0, 3) != 0 &&
             !(replay_ph && clamp_size(int'(new_width), MAX_WIDTH) >
                            clamp_size(int'(width_reg), MAX_WIDTH)))
            write_csr(pru_pkg::CSR_IN_WIDTH, new_width);
         if (seg == 3) long_hold_req = 1'b1;
         repeat ($urandom_range(4, 40)) begin
            op = ($urandom_range(0, 9) == 0) ? ~replay_ph : replay_ph;
            push_request(op, 24'($urandom), 1'b0, '0);
            items_sent++;
         end
         seg++;
      end

      drain_requests();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/pru_pkg.sv
rtl/pru_ifs.sv
rtl/pru_ram.sv
rtl/pru_seq.sv
rtl/pru_emit.sv
rtl/pixel_replication_upscaler.sv
dv/tb_pixel_replication_upscaler.sv
